FILE: src/psd_pkg.sv
// Shared types, constants and register codes for the PPM sum decoder.
`default_nettype none
package psd_pkg;

  localparam int NUM_CHANNELS = 12;
  localparam int IDX_W        = $clog2(NUM_CHANNELS + 1);
  localparam int SLOT_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [15:0] WIDTH_RESET = 16'd1502;
  localparam logic [3:0]  FULL_MASK   = 4'hF;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_GAP      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSE     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FS_THRESHOLD  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FS_ENABLE     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_ORDER = 3'd5;

  localparam logic [15:0] SYNC_GAP_RESET      = 16'd3000;
  localparam logic [15:0] MIN_PULSE_RESET     = 16'd900;
  localparam logic [15:0] MAX_PULSE_RESET     = 16'd2200;
  localparam logic [15:0] FS_THRESHOLD_RESET  = 16'd985;
  localparam logic        FS_ENABLE_RESET     = 1'b1;
  localparam logic [47:0] CHANNEL_ORDER_RESET = 48'hBA98_7654_3210;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [15:0] sync_gap_us;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
    logic [15:0] failsafe_threshold_us;
    logic        failsafe_enable;
    logic [47:0] channel_order;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] timestamp_us;
    logic [3:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        stored_flag;
    logic [3:0]  stored_slot;
    logic        sync_seen;
    logic        failsafe_refresh;
  } result_t;

endpackage
`default_nettype wire

FILE: src/psd_cfg.sv
// Configuration register bank for the PPM sum decoder.
`default_nettype none
module psd_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [psd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output psd_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_gap_us           <= psd_pkg::SYNC_GAP_RESET;
      cfg.min_pulse_us          <= psd_pkg::MIN_PULSE_RESET;
      cfg.max_pulse_us          <= psd_pkg::MAX_PULSE_RESET;
      cfg.failsafe_threshold_us <= psd_pkg::FS_THRESHOLD_RESET;
      cfg.failsafe_enable       <= psd_pkg::FS_ENABLE_RESET;
      cfg.channel_order         <= psd_pkg::CHANNEL_ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        psd_pkg::REG_SYNC_GAP:      cfg.sync_gap_us           <= cfg_data[15:0];
        psd_pkg::REG_MIN_PULSE:     cfg.min_pulse_us          <= cfg_data[15:0];
        psd_pkg::REG_MAX_PULSE:     cfg.max_pulse_us          <= cfg_data[15:0];
        psd_pkg::REG_FS_THRESHOLD:  cfg.failsafe_threshold_us <= cfg_data[15:0];
        psd_pkg::REG_FS_ENABLE:     cfg.failsafe_enable       <= cfg_data[0];
        psd_pkg::REG_CHANNEL_ORDER: cfg.channel_order         <= cfg_data[47:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/psd_core.sv
// Decoder state (edge time, index, width table, good-pulse mask) and per-word logic.
`default_nettype none
module psd_core (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire psd_pkg::cfg_t cfg,
  input  wire psd_pkg::item_t item,
  input  wire logic     advance,
  output psd_pkg::result_t result
);

  localparam int N  = psd_pkg::NUM_CHANNELS;
  localparam int IW = psd_pkg::IDX_W;
  localparam int SW = psd_pkg::SLOT_W;

  logic [15:0]   last_edge_time, last_edge_time_next;
  logic [IW-1:0] channel_index, channel_index_next;
  logic [3:0]    good_pulse_mask, good_pulse_mask_next;
  logic [15:0]   channel_widths [N];

  logic [15:0] gap;
  logic [63:0] order_ext;
  logic [3:0]  phys;
  logic        index_live;
  logic        store;
  logic [3:0]  mask_set;

  assign gap        = item.timestamp_us - last_edge_time;
  assign order_ext  = {16'd0, cfg.channel_order};
  assign phys       = order_ext[{item.read_index, 2'b00} +: 4];
  assign index_live = ({1'b0, channel_index} < (IW + 1)'(N));

  always_comb begin
    result               = '0;
    last_edge_time_next  = last_edge_time;
    channel_index_next   = channel_index;
    good_pulse_mask_next = good_pulse_mask;
    store                = 1'b0;
    mask_set             = good_pulse_mask;
    unique case (item.opcode)
      psd_pkg::OP_READ: begin
        if ({1'b0, item.read_index} < 5'(N) && {1'b0, phys} < 5'(N)) begin
          result.read_value = channel_widths[phys[SW-1:0]];
        end
      end
      psd_pkg::OP_EDGE: begin
        last_edge_time_next = item.timestamp_us;
        if (gap > cfg.sync_gap_us) begin
          channel_index_next = '0;
          result.sync_seen   = 1'b1;
        end else begin
          if (gap > cfg.min_pulse_us && gap < cfg.max_pulse_us && index_live) begin
            store              = 1'b1;
            result.stored_flag = 1'b1;
            result.stored_slot = 4'(channel_index);
            if (cfg.failsafe_enable) begin
              if ({1'b0, channel_index} < (IW + 1)'(4) && gap > cfg.failsafe_threshold_us) begin
                mask_set = good_pulse_mask | (4'd1 << channel_index[1:0]);
              end
              // full mask: clear it and raise the refresh flag
              if (mask_set == psd_pkg::FULL_MASK) begin
                good_pulse_mask_next    = '0;
                result.failsafe_refresh = 1'b1;
              end else begin
                good_pulse_mask_next = mask_set;
              end
            end
          end
          if (index_live) begin
            channel_index_next = channel_index + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time  <= '0;
      channel_index   <= '0;
      good_pulse_mask <= '0;
    end else if (advance) begin
      last_edge_time  <= last_edge_time_next;
      channel_index   <= channel_index_next;
      good_pulse_mask <= good_pulse_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        channel_widths[i] <= psd_pkg::WIDTH_RESET;
      end
    end else if (advance && store) begin
      channel_widths[channel_index[SW-1:0]] <= gap;
    end
  end

endmodule
`default_nettype wire

FILE: src/psd_out_reg.sv
// Result register on the master-side stream.
`default_nettype none
module psd_out_reg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire psd_pkg::result_t result,
  output logic             can_load,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata
);

  psd_pkg::result_t held;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

  assign m_tdata = {1'b0, held.failsafe_refresh, held.sync_seen, held.stored_slot,
                    held.stored_flag, held.read_value};

endmodule
`default_nettype wire

FILE: src/ppm_sum_decoder.sv
// Top level of the PPM sum decoder: input register, decoder core, result register.
`default_nettype none
// PPM sum decoder. Each slave-side word is either an edge event (tuser = 0) carrying
// a wrapping 16-bit microsecond timestamp, or a channel read (tuser = 1). Every word
// yields exactly one master-side word. An edge measures the gap to the previous edge
// modulo 2^16: a gap above sync_gap_us restarts the channel index, a gap strictly
// between min_pulse_us and max_pulse_us is stored as the current channel's width,
// and the index advances, holding at the channel count until the next sync. With
// failsafe enabled, good pulses on channels 0 to 3 fill a mask; a full mask clears
// and raises failsafe_refresh. A read returns a width through channel_order. The
// block takes one word per cycle unless m_tready stalls it. Each word passes the input
// register, then the subtract/compare and table update into the result register.
// Configuration writes (cfg_we, cfg_addr, cfg_data) take effect at once and must be
// issued only while no word is in flight. Channel widths reset to 1502.
module ppm_sum_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [psd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [23:0]                     s_tdata,  // timestamp_us, read_index, pad
  input  wire logic                            s_tuser,  // opcode
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [23:0]                          m_tdata   // read_value, stored_flag,
                                                         // stored_slot, sync_seen,
                                                         // failsafe_refresh, pad
);

  psd_pkg::cfg_t    cfg;
  psd_pkg::item_t   item;
  psd_pkg::result_t result;
  logic             item_valid;
  logic             can_load;
  logic             advance;

  psd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // move the held word into the result register when there is room
  assign advance  = item_valid && can_load;
  assign s_tready = !item_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.opcode       <= s_tuser;
      item.timestamp_us <= s_tdata[15:0];
      item.read_index   <= s_tdata[19:16];
    end
  end

  psd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  psd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the PPM sum decoder: directed table, random frames, checked words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 142;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    psd_pkg::item_t   it;
    bit               typed;
    psd_pkg::result_t want;
  } plan_row_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           cfg_we   = 1'b0;
  logic [psd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [psd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata  = '0;  // timestamp_us, read_index, pad
  logic                           s_tuser  = 1'b0; // opcode
  logic                           m_tvalid;
  logic                           m_tready = 1'b1;
  logic [23:0]                    m_tdata;        // read_value, stored_flag, stored_slot,
                                                  // sync_seen, failsafe_refresh, pad

  // Decoder state as the block should hold it
  psd_pkg::cfg_t              cfg;
  logic [15:0]                last_t;
  logic [psd_pkg::IDX_W-1:0]  ch_idx;
  logic [15:0]                widths [psd_pkg::NUM_CHANNELS];
  logic [3:0]                 mask;

  psd_pkg::result_t decoded_q [$];
  plan_row_t        plan [$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  int n_items = 0, n_reads = 0, n_syncs = 0, n_stores = 0, n_refresh = 0, n_settings = 0;

  ppm_sum_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= rst ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
  end

  // Work out the word the block owes for one accepted item
  task automatic ppm_decode(input psd_pkg::item_t it, output psd_pkg::result_t r);
    logic [15:0] gap;
    logic [3:0]  phys;
    r = '0;
    if (it.opcode == psd_pkg::OP_READ) begin
      if (it.read_index < psd_pkg::NUM_CHANNELS) begin
        phys = cfg.channel_order[4*it.read_index +: 4];
        if (phys < psd_pkg::NUM_CHANNELS) r.read_value = widths[phys];
      end
    end else begin
      gap = it.timestamp_us - last_t;
      last_t = it.timestamp_us;
      if (gap > cfg.sync_gap_us) begin
        ch_idx = '0;
        r.sync_seen = 1'b1;
      end else begin
        if (gap > cfg.min_pulse_us && gap < cfg.max_pulse_us &&
            ch_idx < psd_pkg::NUM_CHANNELS) begin
          widths[ch_idx] = gap;
          r.stored_flag = 1'b1;
          r.stored_slot = 4'(ch_idx);
          if (cfg.failsafe_enable) begin
            if (ch_idx < 4 && gap > cfg.failsafe_threshold_us) mask[ch_idx[1:0]] = 1'b1;
            if (mask == psd_pkg::FULL_MASK) begin
              mask = '0;
              r.failsafe_refresh = 1'b1;
            end
          end
        end
        // hold at the channel count until the next sync
        if (ch_idx < psd_pkg::NUM_CHANNELS) ch_idx = ch_idx + 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    psd_pkg::result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[16], m_tdata[20:17], m_tdata[21], m_tdata[22]};
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
      end else begin
        want = decoded_q.pop_front();
        check_field("read_value", want.read_value, got.read_value);
        check_field("stored_flag", want.stored_flag, got.stored_flag);
        check_field("stored_slot", want.stored_slot, got.stored_slot);
        check_field("sync_seen", want.sync_seen, got.sync_seen);
        check_field("failsafe_refresh", want.failsafe_refresh, got.failsafe_refresh);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge; leaves valid high for the caller to decide
  task automatic push_word(input psd_pkg::item_t it, input bit typed,
                           input psd_pkg::result_t want);
    psd_pkg::result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.opcode;
    s_tdata  <= {4'b0, it.read_index, it.timestamp_us};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ppm_decode(it, r);
    decoded_q.push_back(typed ? want : r);
    n_items++;
    if (it.opcode == psd_pkg::OP_READ) n_reads++;
    n_syncs   += r.sync_seen;
    n_stores  += r.stored_flag;
    n_refresh += r.failsafe_refresh;
    @(negedge clk);
  endtask

  task automatic push_edge(input int gap);
    psd_pkg::item_t it;
    it = '{psd_pkg::OP_EDGE, last_t + 16'(gap), 4'($urandom)};
    push_word(it, 1'b0, '0);
  endtask

  task automatic push_read(input int ridx);
    psd_pkg::item_t it;
    it = '{psd_pkg::OP_READ, 16'($urandom), 4'(ridx)};
    push_word(it, 1'b0, '0);
  endtask

  // Drop valid and hold until every word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [psd_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [psd_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    unique case (addr)
      psd_pkg::REG_SYNC_GAP:      cfg.sync_gap_us = data[15:0];
      psd_pkg::REG_MIN_PULSE:     cfg.min_pulse_us = data[15:0];
      psd_pkg::REG_MAX_PULSE:     cfg.max_pulse_us = data[15:0];
      psd_pkg::REG_FS_THRESHOLD:  cfg.failsafe_threshold_us = data[15:0];
      psd_pkg::REG_FS_ENABLE:     cfg.failsafe_enable = data[0];
      psd_pkg::REG_CHANNEL_ORDER: cfg.channel_order = data[47:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input int p);
    logic [15:0] sg, mn, mx, th;
    logic        en;
    logic [47:0] order;
    order = 48'({$urandom, $urandom});
    unique case (p)
      0: begin sg = 3000; mn = 900; mx = 2200; th = 985; en = 1'b1; end
      1: begin sg = 0; mn = 0; mx = 16'hFFFF; th = 0; en = 1'b1; order = '0; end
      2: begin
        sg = 16'hFFFF; mn = 0; mx = 16'hFFFF; th = 16'hFFFF; en = 1'b0;
        order = 48'hFFFF_FFFF_FFFF;
      end
      3: begin
        sg = 16'($urandom_range(2500, 6000)); mn = 2000; mx = 1000; th = 985; en = 1'b1;
        order = psd_pkg::CHANNEL_ORDER_RESET;
      end
      4: begin sg = 4000; mn = 1500; mx = 1500; th = 1200; en = 1'b0; end
      5: begin
        sg = 3000; mn = 1000; mx = 2000; th = 1500; en = 1'b1;
        order = 48'h0123_4567_89AB;
      end
      default: begin
        sg = 16'($urandom_range(1000, 65535));
        mn = 16'($urandom_range(0, 3000));
        mx = mn + 16'($urandom_range(2, 4000));
        th = 16'($urandom);
        en = 1'($urandom);
      end
    endcase
    // spare high bits of the data bus carry junk
    write_reg(psd_pkg::REG_SYNC_GAP, {$urandom, sg});
    write_reg(psd_pkg::REG_MIN_PULSE, {$urandom, mn});
    write_reg(psd_pkg::REG_MAX_PULSE, {$urandom, mx});
    write_reg(psd_pkg::REG_FS_THRESHOLD, {$urandom, th});
    write_reg(psd_pkg::REG_FS_ENABLE, {$urandom, 15'($urandom), en});
    write_reg(psd_pkg::REG_CHANNEL_ORDER, order);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  function automatic int sync_gap_pick();
    if (cfg.sync_gap_us == 16'hFFFF) return $urandom_range(0, 65535);
    return $urandom_range(int'(cfg.sync_gap_us) + 1, 65535);
  endfunction

  function automatic int pulse_gap_pick();
    int lo, hi;
    lo = int'(cfg.min_pulse_us) + 1;
    hi = int'(cfg.max_pulse_us) - 1;
    if (hi > int'(cfg.sync_gap_us)) hi = int'(cfg.sync_gap_us);
    if (lo > hi) return $urandom_range(0, int'(cfg.sync_gap_us));
    return $urandom_range(lo, hi);
  endfunction

  // Sync, then a run of channel gaps, mostly in the window, with the odd read between
  task automatic send_frame();
    int k;
    push_edge(sync_gap_pick());
    k = $urandom_range(1, 14);
    repeat (k) begin
      if ($urandom_range(0, 99) < 85) push_edge(pulse_gap_pick());
      else push_edge($urandom_range(0, int'(cfg.sync_gap_us)));
      if ($urandom_range(0, 99) < 12) push_read($urandom_range(0, 15));
    end
  endtask

  task automatic add_row(input logic op, input int ts, input int ridx, input bit typed,
                         input int rv, input bit st, input int sl, input bit sy, input bit rf);
    plan_row_t row;
    row.it    = '{op, 16'(ts), 4'(ridx)};
    row.typed = typed;
    row.want  = '{16'(rv), st, 4'(sl), sy, rf};
    plan.push_back(row);
  endtask

  initial begin
    int  start;
    int  pick;
    bit  paused;
    cfg = '{psd_pkg::SYNC_GAP_RESET, psd_pkg::MIN_PULSE_RESET, psd_pkg::MAX_PULSE_RESET,
            psd_pkg::FS_THRESHOLD_RESET, psd_pkg::FS_ENABLE_RESET,
            psd_pkg::CHANNEL_ORDER_RESET};
    last_t = '0;
    ch_idx = '0;
    mask   = '0;
    foreach (widths[i]) widths[i] = psd_pkg::WIDTH_RESET;
    paused = 1'b0;

    add_row(psd_pkg::OP_READ, 0, 0, 1, 1502, 0, 0, 0, 0);
    add_row(psd_pkg::OP_READ, 0, 11, 1, 1502, 0, 0, 0, 0);
    add_row(psd_pkg::OP_READ, 0, 12, 1, 0, 0, 0, 0, 0);    // index past the table
    add_row(psd_pkg::OP_READ, 65535, 15, 1, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_EDGE, 0, 0, 1, 0, 0, 0, 0, 0);     // zero gap
    add_row(psd_pkg::OP_EDGE, 65535, 15, 1, 0, 0, 0, 1, 0); // largest gap: sync
    add_row(psd_pkg::OP_EDGE, 1499, 0, 1, 0, 1, 0, 0, 0);   // gap wraps through zero
    add_row(psd_pkg::OP_EDGE, 3099, 0, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_EDGE, 4799, 0, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_EDGE, 6599, 0, 0, 0, 0, 0, 0, 0);   // mask fills: refresh
    add_row(psd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_READ, 0, 3, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_EDGE, 7499, 0, 1, 0, 0, 0, 0, 0);   // gap on the lower bound
    add_row(psd_pkg::OP_EDGE, 9699, 0, 1, 0, 0, 0, 0, 0);   // gap on the upper bound
    add_row(psd_pkg::OP_EDGE, 10600, 0, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_EDGE, 12799, 0, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_EDGE, 15799, 0, 1, 0, 0, 0, 0, 0);  // gap equal to the sync limit
    add_row(psd_pkg::OP_EDGE, 18800, 0, 1, 0, 0, 0, 1, 0);  // one above: sync
    add_row(psd_pkg::OP_READ, 0, 6, 0, 0, 0, 0, 0, 0);
    add_row(psd_pkg::OP_READ, 0, 7, 0, 0, 0, 0, 0, 0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) push_word(plan[i].it, plan[i].typed, plan[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_setting(p);
      unique case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        if (p == 2 && !paused && n_items - start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_frame();
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 4)) push_edge($urandom_range(0, 65535));
        end else begin
          repeat ($urandom_range(1, 3)) push_read($urandom_range(0, 15));
        end
      end
    end
    drain();

    if (decoded_q.size() != 0) begin
      errors += decoded_q.size();
      $display("%0t: %0d expected words never arrived", $time, decoded_q.size());
    end

    $display("Run covered %0d words (%0d reads) over %0d register settings;",
             n_items, n_reads, n_settings);
    $display("  %0d frame syncs, %0d stored widths, %0d failsafe refreshes.",
             n_syncs, n_stores, n_refresh);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
